### sv/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/ccr_pkg.sv
`default_nettype none
package ccr_pkg;
	localparam int MaxColumns = 64;
	localparam int MaxRows    = 64;
	localparam int ColW  = $clog2(MaxColumns);
	localparam int RowW  = $clog2(MaxRows);
	localparam int AddrW = ColW + RowW;
	localparam logic [7:0] SpaceChar = 8'd32;

	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_POINT = 3'd1;
	localparam logic [2:0] OP_LINE  = 3'd2;
	localparam logic [2:0] OP_RECT  = 3'd3;
	localparam logic [2:0] OP_FILL  = 3'd4;
	localparam logic [2:0] OP_DISK  = 3'd5;
	localparam logic [2:0] OP_READ  = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture item and set up
		logic scan_init; // sweep starts at (0,0)
		logic scan_step; // sweep advances, writes when selected
		logic line_step; // Bresenham step, writes when inside
		logic point_wr;  // single-cell write
		logic rd_issue;  // memory read
		logic res_load;  // capture result
		logic wipe_step; // reset clearing pass
	} ccr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic line_last;
		logic wipe_last;
	} ccr_sts_t;
endpackage
`default_nettype wire

### sv/ccr_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module ccr_datapath import ccr_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ccr_cmd_t        cmd,
	output ccr_sts_t             sts,
	input  wire logic [2:0]      operation,
	input  wire logic signed [8:0] start_x,
	input  wire logic signed [8:0] start_y,
	input  wire logic signed [8:0] end_x,
	input  wire logic signed [8:0] end_y,
	input  wire logic [7:0]      radius,
	input  wire logic [7:0]      fill_char,
	input  wire logic [6:0]      width_q_i,
	input  wire logic [6:0]      height_q_i,
	output logic [7:0]           read_char_q,
	output logic                 read_valid_q
);
	logic [7:0] mem [MaxColumns*MaxRows];

	logic [2:0]        op_q;
	logic signed [10:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [10:0] dx_q, dy_q;
	logic              sx_q, sy_q;
	logic signed [11:0] err_q;
	logic [16:0]       r2_q;
	logic [7:0]        ch_q;
	logic [ColW:0]     aw_q;
	logic [RowW:0]     ah_q;
	logic [ColW-1:0]   cx_q;
	logic [RowW-1:0]   cy_q;
	logic [AddrW-1:0]  wipe_q;
	logic              rd_ok_q;
	logic [7:0]        rd_data_q;

	// active canvas, clamped to the store
	logic [ColW:0] aw_c;
	logic [RowW:0] ah_c;
	always_comb begin
		aw_c = (width_q_i > 7'(MaxColumns)) ? (ColW+1)'(MaxColumns) : (ColW+1)'(width_q_i);
		ah_c = (height_q_i > 7'(MaxRows)) ? (RowW+1)'(MaxRows) : (RowW+1)'(height_q_i);
	end

	// scan cell selection; an empty canvas selects nothing
	logic signed [10:0] scx, scy, ddx, ddy;
	logic [21:0] ddx2, ddy2;
	logic sel_c;
	logic scan_in;
	always_comb begin
		scx  = 11'(cx_q);
		scy  = 11'(cy_q);
		ddx  = scx - x1_q;
		ddy  = scy - y1_q;
		ddx2 = 22'(ddx * ddx);
		ddy2 = 22'(ddy * ddy);
		scan_in = scx < 11'(aw_q) && scy < 11'(ah_q);
		case (op_q)
			OP_CLEAR: sel_c = 1'b1;
			OP_FILL:  sel_c = scx >= x1_q && scx <= x2_q && scy >= y1_q && scy <= y2_q;
			OP_RECT:  sel_c = scx >= x1_q && scx <= x2_q && scy >= y1_q && scy <= y2_q
				&& (scx == x1_q || scx == x2_q || scy == y1_q || scy == y2_q);
			OP_DISK:  sel_c = (23'(ddx2) + 23'(ddy2)) <= 23'(r2_q);
			default:  sel_c = 1'b0;
		endcase
	end

	// line point inside canvas
	logic ln_in;
	always_comb begin
		ln_in = x1_q >= 0 && y1_q >= 0 && x1_q < 11'(aw_q) && y1_q < 11'(ah_q);
	end

	logic signed [12:0] e2;
	assign e2 = 13'(err_q) <<< 1;

	assign sts.scan_last = (12'(cx_q) + 12'd1 >= 12'(aw_q)) &&
		(12'(cy_q) + 12'd1 >= 12'(ah_q));
	assign sts.line_last = x1_q == x2_q && y1_q == y2_q;
	assign sts.wipe_last = &wipe_q;

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q <= '0;
		end else if (cmd.wipe_step) begin
			wipe_q <= wipe_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			x1_q <= 11'(start_x);
			y1_q <= 11'(start_y);
			x2_q <= 11'(end_x);
			y2_q <= 11'(end_y);
			ch_q <= (operation == OP_CLEAR) ? SpaceChar : fill_char;
			r2_q <= 17'(radius * radius);
			dx_q <= (end_x > start_x) ? 11'(end_x) - 11'(start_x) : 11'(start_x) - 11'(end_x);
			dy_q <= (end_y > start_y) ? 11'(end_y) - 11'(start_y) : 11'(start_y) - 11'(end_y);
			err_q <= ((end_x > start_x) ? 12'(end_x) - 12'(start_x) : 12'(start_x) - 12'(end_x))
				- ((end_y > start_y) ? 12'(end_y) - 12'(start_y) : 12'(start_y) - 12'(end_y));
			sx_q <= start_x < end_x;
			sy_q <= start_y < end_y;
			aw_q <= aw_c;
			ah_q <= ah_c;
		end
		if (cmd.scan_init) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.scan_step) begin
			if (12'(cx_q) + 12'd1 >= 12'(aw_q)) begin
				cx_q <= '0;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
		if (cmd.line_step) begin
			if (e2 > -13'(dy_q) && e2 < 13'(dx_q)) begin
				err_q <= err_q - 12'(dy_q) + 12'(dx_q);
			end else if (e2 > -13'(dy_q)) begin
				err_q <= err_q - 12'(dy_q);
			end else if (e2 < 13'(dx_q)) begin
				err_q <= err_q + 12'(dx_q);
			end
			if (e2 > -13'(dy_q)) x1_q <= sx_q ? x1_q + 11'sd1 : x1_q - 11'sd1;
			if (e2 < 13'(dx_q))  y1_q <= sy_q ? y1_q + 11'sd1 : y1_q - 11'sd1;
		end
		if (cmd.rd_issue) begin
			rd_ok_q <= ln_in && op_q == OP_READ;
		end
		if (cmd.res_load) begin
			read_valid_q <= rd_ok_q;
			read_char_q  <= rd_ok_q ? rd_data_q : 8'd0;
		end
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (cmd.wipe_step) begin
			mem[wipe_q] <= SpaceChar;
		end else if (cmd.scan_step && sel_c && scan_in) begin
			mem[{cy_q, cx_q}] <= ch_q;
		end else if ((cmd.line_step || cmd.point_wr) && ln_in) begin
			mem[{y1_q[RowW-1:0], x1_q[ColW-1:0]}] <= ch_q;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[{y1_q[RowW-1:0], x1_q[ColW-1:0]}];
		end
	end

	`ASSERT_IMPL(a_one_cmd, cmd.scan_step, !cmd.line_step && !cmd.wipe_step)
	`ASSERT_IMPL(a_line_in, cmd.line_step && ln_in, x1_q < 11'(MaxColumns))
	`ASSERT_NEXT(a_res_zero, cmd.res_load && !rd_ok_q, read_char_q == 8'd0)
endmodule
`default_nettype wire

### sv/ccr_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module ccr_ctrl import ccr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_go,
	input  wire logic [2:0] operation,
	input  wire logic       out_taken,
	input  wire ccr_sts_t   sts,
	output ccr_cmd_t        cmd,
	output logic            in_ready,
	output logic            out_valid
);
	typedef enum logic [6:0] {
		S_WIPE = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_LINE = 7'b0001000,
		S_ONE  = 7'b0010000,
		S_RES  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;
	state_t state_q, next_c;
	logic [2:0] op_q;

	// next state and commands
	always_comb begin
		next_c = state_q;
		cmd = '0;
		case (state_q)
			S_WIPE: begin
				cmd.wipe_step = 1'b1;
				if (sts.wipe_last) next_c = S_IDLE;
			end
			S_IDLE: begin
				if (in_go) begin
					cmd.load = 1'b1;
					cmd.scan_init = 1'b1;
					case (operation)
						OP_CLEAR, OP_RECT, OP_FILL, OP_DISK: next_c = S_SCAN;
						OP_LINE: next_c = S_LINE;
						default: next_c = S_ONE;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) next_c = S_ONE;
			end
			S_LINE: begin
				cmd.line_step = 1'b1;
				if (sts.line_last) next_c = S_ONE;
			end
			S_ONE: begin
				cmd.rd_issue = 1'b1;
				cmd.point_wr = op_q == OP_POINT;
				next_c = S_RES;
			end
			S_RES: begin
				cmd.res_load = 1'b1;
				next_c = S_OUT;
			end
			S_OUT: begin
				if (out_taken) next_c = S_IDLE;
			end
			default: next_c = S_IDLE;
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			op_q    <= OP_CLEAR;
		end else begin
			state_q <= next_c;
			if (cmd.load) op_q <= operation;
		end
	end

	`ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_q))
	`ASSERT_NEXT(a_res_out, state_q == S_RES, out_valid)
	`ASSERT_IMPL(a_no_in, out_valid, !in_ready)
endmodule
`default_nettype wire

### sv/character_canvas_rasterizer.sv
// Channel | Handshake          | Payload
// command | valid / ready      | operation start_x start_y end_x end_y radius fill_char
// result  | out_valid/out_ready| read_char read_valid
// config  | APB write/read     | canvas_width (0x0), canvas_height (0x4)
// After reset a clearing pass sets every cell to space; no item is taken meanwhile.
// Clear, fill, rectangle and disk sweep the active canvas, one cell a cycle.
// A line steps one point a cycle; point, read and code 7 go straight to the read and result steps.
// The single write port of the cell memory sets this pace; one item is worked on at a time.
// The result is held until out_ready; the next item is taken the cycle after it has gone.
`default_nettype none
module character_canvas_rasterizer import ccr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid,
	output logic                   ready,
	input  wire logic [2:0]        operation,
	input  wire logic signed [8:0] start_x,
	input  wire logic signed [8:0] start_y,
	input  wire logic signed [8:0] end_x,
	input  wire logic signed [8:0] end_y,
	input  wire logic [7:0]        radius,
	input  wire logic [7:0]        fill_char,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             read_char,
	output logic                   read_valid,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	logic [6:0] width_q, height_q;
	ccr_cmd_t cmd;
	ccr_sts_t sts;

	// register file
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			if (paddr == 3'd0) width_q <= pwdata[6:0];
			if (paddr == 3'd4) height_q <= pwdata[6:0];
		end
	end
	always_comb begin
		case (paddr)
			3'd0:    prdata = {25'd0, width_q};
			3'd4:    prdata = {25'd0, height_q};
			default: prdata = '0;
		endcase
	end

	ccr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_go(valid && ready),
		.operation,
		.out_taken(out_ready),
		.sts, .cmd,
		.in_ready(ready),
		.out_valid
	);

	ccr_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.operation, .start_x, .start_y, .end_x, .end_y, .radius, .fill_char,
		.width_q_i(width_q), .height_q_i(height_q),
		.read_char_q(read_char), .read_valid_q(read_valid)
	);
endmodule
`default_nettype wire
